FILE: sv/msf_pkg.sv
// shared types and constants of the memory value search filter
package msf_pkg;

    // command codes carried with each request
    localparam logic [1:0] CMD_START    = 2'd0;
    localparam logic [1:0] CMD_CONTINUE = 2'd1;
    localparam logic [1:0] CMD_QUERY    = 2'd2;

    // configuration register indexes
    localparam logic REG_MODE_SEL     = 1'b0;
    localparam logic REG_SEARCH_VALUE = 1'b1;

    // compare codes used in compare search
    localparam logic [7:0] CMP_EQ = 8'h00;
    localparam logic [7:0] CMP_NE = 8'h01;
    localparam logic [7:0] CMP_LT = 8'h02;
    localparam logic [7:0] CMP_LE = 8'h03;
    localparam logic [7:0] CMP_GT = 8'h04;
    localparam logic [7:0] CMP_GE = 8'h05;

    localparam logic [7:0]  FULL_MASK = 8'hFF;
    localparam int          TOTAL_W   = 17;
    localparam logic [16:0] TOTAL_MAX = 17'd65536;

    typedef enum logic [1:0] {
        MODE_ABSOLUTE = 2'd0,
        MODE_RELATIVE = 2'd1,
        MODE_BIT_FLIP = 2'd2,
        MODE_COMPARE  = 2'd3
    } mode_t;

    // one store entry: match mask and previous byte
    typedef struct packed {
        logic [7:0] prev;
        logic [7:0] mask;
    } entry_t;

    // outcome of one read-modify-write step
    typedef struct packed {
        logic               write;
        entry_t             entry;
        logic [7:0]         result_mask;
        logic [TOTAL_W-1:0] total;
    } upd_t;

endpackage

FILE: sv/memory_value_search_filter.sv
// top level of the memory value search filter
// Each request names a byte index, the byte's current value and a command (start,
// continue, query); the block answers with the index's match mask after the step
// and the number of indices still matching. Mask and previous byte of every index
// live in one ram entry; a request reads the entry in its accept cycle, then, once the
// output register is free, computes, writes back and loads the output register, so the
// block takes one request per cycle while the output does not stall. A request to the
// index last written back is served from a forwarding register. After reset a clearing
// pass writes every ram entry, while no request is accepted; configuration writes are
// taken at any time. Indices at or beyond the window change nothing and report a zero
// mask.
module memory_value_search_filter #(
    parameter int WINDOW_BYTES = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // command[1:0], byte_index[17:2], byte_value[25:18]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // match_mask[7:0], match_total[24:8]
);

    localparam int DEPTH = (WINDOW_BYTES < 65536) ? WINDOW_BYTES : 65536;
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = $bits(msf_pkg::entry_t);

    msf_pkg::mode_t mode_sel_reg;
    logic [7:0]     search_value_reg;

    logic          clr_reg;
    logic [AW-1:0] clr_addr_reg;

    logic          b_valid_reg;
    logic [1:0]    b_cmd_reg;
    logic [AW-1:0] b_addr_reg;
    logic [7:0]    b_val_reg;
    logic          b_inwin_reg;

    logic          fw_valid_reg;
    logic [AW-1:0] fw_addr_reg;
    logic [EW-1:0] fw_data_reg;

    logic [msf_pkg::TOTAL_W-1:0] total_reg;
    logic                        m_tvalid_reg;
    logic [31:0]                 m_tdata_reg;

    logic          s_accept;
    logic          out_free;
    logic          b_adv;
    logic          in_win;
    logic [AW-1:0] rd_addr;
    logic [EW-1:0] ram_rdata;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    msf_pkg::entry_t old_entry;
    msf_pkg::upd_t   upd;

    // handshake
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign b_adv     = b_valid_reg && out_free;
    assign s_tready  = !clr_reg && (!b_valid_reg || out_free);
    assign s_accept  = s_tvalid && s_tready;
    assign in_win    = ({1'b0, s_tdata[17:2]} < 17'(DEPTH));
    assign rd_addr   = s_tdata[2 +: AW];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_sel_reg     <= msf_pkg::MODE_ABSOLUTE;
            search_value_reg <= 8'h00;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                msf_pkg::REG_MODE_SEL:     mode_sel_reg     <= msf_pkg::mode_t'(cfg_data[1:0]);
                msf_pkg::REG_SEARCH_VALUE: search_value_reg <= cfg_data;
                default:                   search_value_reg <= search_value_reg;
            endcase
        end
    end

    // clearing pass over the store after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                clr_reg <= 1'b0;
            end
        end
    end

    // entry store
    assign ram_we    = clr_reg || (b_adv && upd.write);
    assign ram_waddr = clr_reg ? clr_addr_reg : b_addr_reg;
    assign ram_wdata = clr_reg ? '0 : upd.entry;

    msf_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (s_accept),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // request held while its entry is read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            b_valid_reg <= 1'b1;
        end
        else if (b_adv)
        begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            b_cmd_reg   <= s_tdata[1:0];
            b_addr_reg  <= rd_addr;
            b_val_reg   <= s_tdata[25:18];
            b_inwin_reg <= in_win;
        end
    end

    // forwarding of the most recent write-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_valid_reg <= 1'b0;
        end
        else if (b_adv && upd.write)
        begin
            fw_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_adv && upd.write)
        begin
            fw_addr_reg <= b_addr_reg;
            fw_data_reg <= upd.entry;
        end
    end

    assign old_entry = (fw_valid_reg && fw_addr_reg == b_addr_reg) ? fw_data_reg : ram_rdata;

    // modify step
    msf_update u_update (
        .command      (b_cmd_reg),
        .mode_sel     (mode_sel_reg),
        .search_value (search_value_reg),
        .byte_value   (b_val_reg),
        .in_window    (b_inwin_reg),
        .old_entry    (old_entry),
        .total        (total_reg),
        .upd          (upd)
    );

    // match count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
        end
        else if (b_adv)
        begin
            total_reg <= upd.total;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (b_adv)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_adv)
        begin
            m_tdata_reg <= {7'b0, upd.total, upd.result_mask};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // no request enters during the clearing pass
    assert property (@(posedge clk) disable iff (!rst_n) clr_reg |-> !s_tready)
        else $error("request accepted during clearing pass");

    // match count stays within its bound
    assert property (@(posedge clk) disable iff (!rst_n) total_reg <= msf_pkg::TOTAL_MAX)
        else $error("match count above bound");

    // a request beyond the window reports a zero mask
    assert property (@(posedge clk) disable iff (!rst_n)
        (b_adv && !b_inwin_reg) |=> (m_tdata_reg[7:0] == 8'h00))
        else $error("nonzero mask outside window");

    // the count moves by at most one per step
    assert property (@(posedge clk) disable iff (!rst_n)
        b_adv |=> (total_reg == $past(total_reg) || total_reg == $past(total_reg) + 1'b1
                   || total_reg + 1'b1 == $past(total_reg)))
        else $error("match count jumped");

endmodule

FILE: sv/msf_ram.sv
// generic single-port-write, single-port-read ram with registered read
module msf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/msf_update.sv
// next entry, result mask and match count for one search step
module msf_update (
    input  logic [1:0]                  command,
    input  msf_pkg::mode_t              mode_sel,
    input  logic [7:0]                  search_value,
    input  logic [7:0]                  byte_value,
    input  logic                        in_window,
    input  msf_pkg::entry_t             old_entry,
    input  logic [msf_pkg::TOTAL_W-1:0] total,
    output msf_pkg::upd_t               upd
);

    logic       cmp_pass;
    logic [7:0] flipped;
    logic [7:0] rel_sum;
    logic [7:0] new_mask;
    logic [7:0] new_prev;
    logic       write;
    logic       dec;
    logic       inc;
    logic [msf_pkg::TOTAL_W-1:0] total_dn;
    logic [msf_pkg::TOTAL_W-1:0] total_new;

    assign flipped = old_entry.prev ^ byte_value;
    assign rel_sum = old_entry.prev + search_value;

    // compare search against the previous byte
    always_comb
    begin
        case (search_value)
            msf_pkg::CMP_EQ: cmp_pass = (byte_value == old_entry.prev);
            msf_pkg::CMP_NE: cmp_pass = (byte_value != old_entry.prev);
            msf_pkg::CMP_LT: cmp_pass = (byte_value <  old_entry.prev);
            msf_pkg::CMP_LE: cmp_pass = (byte_value <= old_entry.prev);
            msf_pkg::CMP_GT: cmp_pass = (byte_value >  old_entry.prev);
            msf_pkg::CMP_GE: cmp_pass = (byte_value >= old_entry.prev);
            default:         cmp_pass = 1'b0;
        endcase
    end

    // new mask and previous byte per command and mode
    always_comb
    begin
        new_mask = old_entry.mask;
        new_prev = old_entry.prev;
        write    = 1'b0;
        dec      = 1'b0;
        inc      = 1'b0;
        if (in_window && command == msf_pkg::CMD_START)
        begin
            write = 1'b1;
            if (mode_sel == msf_pkg::MODE_ABSOLUTE)
            begin
                new_mask = (byte_value == search_value) ? msf_pkg::FULL_MASK : 8'h00;
                new_prev = 8'h00;
            end
            else
            begin
                new_mask = msf_pkg::FULL_MASK;
                new_prev = byte_value;
            end
            dec = (old_entry.mask != 8'h00);
            inc = (new_mask != 8'h00);
        end
        else if (in_window && command == msf_pkg::CMD_CONTINUE
                 && old_entry.mask != 8'h00)
        begin
            write = 1'b1;
            unique case (mode_sel)
                msf_pkg::MODE_ABSOLUTE:
                begin
                    if (byte_value != search_value)
                    begin
                        new_mask = 8'h00;
                    end
                end
                msf_pkg::MODE_RELATIVE:
                begin
                    if (rel_sum != byte_value)
                    begin
                        new_mask = 8'h00;
                    end
                    else
                    begin
                        new_prev = byte_value;
                    end
                end
                msf_pkg::MODE_BIT_FLIP:
                begin
                    if (search_value != 8'h00)
                    begin
                        new_mask = old_entry.mask & flipped;
                    end
                    else
                    begin
                        new_mask = old_entry.mask & ~flipped;
                    end
                    if (new_mask != 8'h00)
                    begin
                        new_prev = byte_value;
                    end
                end
                msf_pkg::MODE_COMPARE:
                begin
                    if (cmp_pass)
                    begin
                        new_prev = byte_value;
                    end
                    else
                    begin
                        new_mask = 8'h00;
                    end
                end
                default:
                begin
                    new_mask = old_entry.mask;
                end
            endcase
            dec = (new_mask == 8'h00);
        end
    end

    // saturating count adjust, down first then up
    always_comb
    begin
        total_dn = total;
        if (dec && total != '0)
        begin
            total_dn = total - 1'b1;
        end
        total_new = total_dn;
        if (inc && total_dn < msf_pkg::TOTAL_MAX)
        begin
            total_new = total_dn + 1'b1;
        end
    end

    assign upd.total       = total_new;
    assign upd.write       = write;
    assign upd.entry.mask  = new_mask;
    assign upd.entry.prev  = new_prev;
    assign upd.result_mask = in_window ? new_mask : 8'h00;

endmodule

FILE: tb/sv/memory_value_search_filter_test.sv
// testbench of the memory value search filter: directed table, random sweeps, scoreboard
`timescale 1ns / 1ps

module memory_value_search_filter_test;

    localparam int         SWEEP_TARGET = 1850;
    localparam int         CYCLE_LIMIT  = 600000;
    localparam int         SETTLE       = 8;
    localparam int         MAX_REPORTS  = 10;
    localparam logic [1:0] CMD_UNKNOWN  = 2'd3;
    localparam logic [7:0] CMP_UNKNOWN  = 8'h06;

    typedef struct packed {
        logic [7:0]                  mask;
        logic [msf_pkg::TOTAL_W-1:0] total;
    } match_t;

    typedef enum { ROW_WRITE, ROW_KNOWN, ROW_PREDICT } row_kind_t;

    typedef struct {
        row_kind_t  kind;
        logic       sel;
        logic [1:0] cmd;
        logic [15:0] idx;
        logic [7:0] val;
        match_t     want;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [7:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    // own copy of the search state
    logic [7:0]                  cand_mask [0:65535];
    logic [7:0]                  last_byte [0:65535];
    logic [msf_pkg::TOTAL_W-1:0] hit_total;
    msf_pkg::mode_t              cur_mode;
    logic [7:0]                  cur_value;

    match_t pending_matches [$];
    row_t   plan [$];

    bit steady;
    int errors;
    int checked;
    int sent;
    int swept;
    int phases;
    int cycles;
    int mode_phases [4];

    memory_value_search_filter i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic bit cmp_holds(input logic [7:0] code, input logic [7:0] now,
                                     input logic [7:0] prev);
        case (code)
            msf_pkg::CMP_EQ: return now == prev;
            msf_pkg::CMP_NE: return now != prev;
            msf_pkg::CMP_LT: return now < prev;
            msf_pkg::CMP_LE: return now <= prev;
            msf_pkg::CMP_GT: return now > prev;
            msf_pkg::CMP_GE: return now >= prev;
            default:         return 1'b0;
        endcase
    endfunction

    // one read-modify-write of an entry, returns the mask and count it reports
    function automatic match_t narrow_entry(input logic [1:0] cmd, input logic [15:0] idx,
                                            input logic [7:0] val);
        logic [7:0] old_mask;
        logic [7:0] new_mask;
        logic [7:0] prev;
        logic [7:0] stepped;
        logic [7:0] flipped;
        match_t     res;
        old_mask = cand_mask[idx];
        prev     = last_byte[idx];
        new_mask = old_mask;
        if (cmd == msf_pkg::CMD_START)
        begin
            if (cur_mode == msf_pkg::MODE_ABSOLUTE)
            begin
                new_mask = (val == cur_value) ? msf_pkg::FULL_MASK : 8'h00;
                prev     = 8'h00;
            end
            else
            begin
                new_mask = msf_pkg::FULL_MASK;
                prev     = val;
            end
            if (old_mask != 8'h00 && hit_total > 0)
                hit_total--;
            if (new_mask != 8'h00 && hit_total < msf_pkg::TOTAL_MAX)
                hit_total++;
        end
        else if (cmd == msf_pkg::CMD_CONTINUE && old_mask != 8'h00)
        begin
            case (cur_mode)
                msf_pkg::MODE_ABSOLUTE:
                begin
                    if (val != cur_value)
                        new_mask = 8'h00;
                end
                msf_pkg::MODE_RELATIVE:
                begin
                    stepped = prev + cur_value;
                    if (stepped != val)
                        new_mask = 8'h00;
                    else
                        prev = val;
                end
                msf_pkg::MODE_BIT_FLIP:
                begin
                    // all eight bits at once against the previous byte
                    flipped  = prev ^ val;
                    new_mask = (cur_value != 8'h00) ? (old_mask & flipped)
                                                    : (old_mask & ~flipped);
                    if (new_mask != 8'h00)
                        prev = val;
                end
                default:
                begin
                    if (cmp_holds(cur_value, val, prev))
                        prev = val;
                    else
                        new_mask = 8'h00;
                end
            endcase
            if (new_mask == 8'h00 && hit_total > 0)
                hit_total--;
        end
        cand_mask[idx] = new_mask;
        last_byte[idx] = prev;
        res.mask  = new_mask;
        res.total = hit_total;
        return res;
    endfunction

    // a byte value that most likely keeps a candidate alive
    function automatic logic [7:0] keep_candidate_value(input logic [15:0] idx);
        logic [7:0] prev;
        logic [7:0] low;
        logic [7:0] r;
        prev = last_byte[idx];
        low  = cand_mask[idx] & (~cand_mask[idx] + 8'd1);
        r    = 8'($urandom);
        case (cur_mode)
            msf_pkg::MODE_ABSOLUTE: return cur_value;
            msf_pkg::MODE_RELATIVE: return prev + cur_value;
            msf_pkg::MODE_BIT_FLIP:
            begin
                if (cur_value != 8'h00)
                    return prev ^ (r | low);
                return prev ^ (r & ~low);
            end
            default:
            begin
                case (cur_value) inside
                    msf_pkg::CMP_EQ, msf_pkg::CMP_LE, msf_pkg::CMP_GE: return prev;
                    msf_pkg::CMP_NE: return prev ^ (r | 8'h01);
                    msf_pkg::CMP_LT:
                        return (prev == 8'h00) ? r
                                               : 8'($urandom_range(int'(prev) - 1, 0));
                    msf_pkg::CMP_GT:
                        return (prev == 8'hFF) ? r
                                               : 8'($urandom_range(255, int'(prev) + 1));
                    default: return r;
                endcase
            end
        endcase
    endfunction

    function automatic logic [7:0] draw_search_value(input msf_pkg::mode_t mode);
        case (mode) inside
            msf_pkg::MODE_ABSOLUTE, msf_pkg::MODE_RELATIVE:
            begin
                if ($urandom_range(9) == 0)
                    return $urandom_range(1) ? 8'hFF : 8'h00;
                return 8'($urandom);
            end
            msf_pkg::MODE_BIT_FLIP:
                return $urandom_range(1) ? 8'h00 : 8'($urandom_range(255, 1));
            default:
            begin
                if ($urandom_range(99) < 85)
                    return 8'($urandom_range(5, 0));
                return 8'($urandom_range(255, 6));
            end
        endcase
    endfunction

    task automatic flag_mismatch(input string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("mismatch: %s", msg);
    endtask

    // result side: random stalls and scoreboard
    always @(posedge clk)
    begin : check_results
        match_t got;
        match_t want;
        m_tready <= steady || ($urandom_range(99) >= 11);
        if (m_tvalid && m_tready)
        begin
            got.mask  = m_tdata[7:0];
            got.total = m_tdata[24:8];
            checked++;
            if (pending_matches.size() == 0)
                flag_mismatch($sformatf("result with no request waiting: mask %02h total %0d",
                                        got.mask, got.total));
            else
            begin
                want = pending_matches.pop_front();
                if (got !== want)
                    flag_mismatch($sformatf(
                        "result %0d: expected mask %02h total %0d, got mask %02h total %0d",
                        checked, want.mask, want.total, got.mask, got.total));
            end
        end
    end

    task automatic write_register(input logic sel, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (sel == msf_pkg::REG_MODE_SEL)
            cur_mode = msf_pkg::mode_t'(data[1:0]);
        else
            cur_value = data;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // sender holds off until every result is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_matches.size() != 0)
            @(posedge clk);
    endtask

    task automatic issue_request(input logic [1:0] cmd, input logic [15:0] idx,
                                 input logic [7:0] val, input bit known, input match_t typed);
        match_t predicted;
        while (!steady && $urandom_range(99) < 11)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, val, idx, cmd};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = narrow_entry(cmd, idx, val);
        pending_matches.push_back(known ? typed : predicted);
        sent++;
    endtask

    // new mode and value, written in random order with junk in the unused mode bits
    task automatic set_search(input msf_pkg::mode_t mode, input logic [7:0] value);
        logic [7:0] mode_data;
        mode_data      = 8'($urandom);
        mode_data[1:0] = mode;
        wait_drained();
        mode_phases[mode]++;
        if ($urandom_range(1))
        begin
            write_register(msf_pkg::REG_MODE_SEL, mode_data);
            write_register(msf_pkg::REG_SEARCH_VALUE, value);
        end
        else
        begin
            write_register(msf_pkg::REG_SEARCH_VALUE, value);
            write_register(msf_pkg::REG_MODE_SEL, mode_data);
        end
    endtask

    task automatic add_write(input logic sel, input logic [7:0] data);
        row_t r;
        r.kind = ROW_WRITE;
        r.sel  = sel;
        r.val  = data;
        plan.push_back(r);
    endtask

    task automatic add_known(input logic [1:0] cmd, input logic [15:0] idx, input logic [7:0] val,
                             input logic [7:0] mask, input logic [msf_pkg::TOTAL_W-1:0] total);
        row_t r;
        r.kind       = ROW_KNOWN;
        r.cmd        = cmd;
        r.idx        = idx;
        r.val        = val;
        r.want.mask  = mask;
        r.want.total = total;
        plan.push_back(r);
    endtask

    task automatic add_check(input logic [1:0] cmd, input logic [15:0] idx,
                             input logic [7:0] val);
        row_t r;
        r.kind = ROW_PREDICT;
        r.cmd  = cmd;
        r.idx  = idx;
        r.val  = val;
        plan.push_back(r);
    endtask

    // directed rows: extremes, every command, every mode and the odd cases
    task automatic build_plan();
        add_write(msf_pkg::REG_MODE_SEL, 8'(msf_pkg::MODE_ABSOLUTE));
        add_write(msf_pkg::REG_SEARCH_VALUE, 8'h00);
        add_known(msf_pkg::CMD_QUERY, 16'h0000, 8'h00, 8'h00, '0);
        add_known(CMD_UNKNOWN, 16'hFFFF, 8'hFF, 8'h00, '0);
        add_known(msf_pkg::CMD_START, 16'h0000, 8'h00, msf_pkg::FULL_MASK, 17'd1);
        add_known(msf_pkg::CMD_START, 16'hFFFF, 8'hFF, 8'h00, 17'd1);
        add_write(msf_pkg::REG_SEARCH_VALUE, 8'hFF);
        add_known(msf_pkg::CMD_START, 16'hFFFF, 8'hFF, msf_pkg::FULL_MASK, 17'd2);
        add_known(msf_pkg::CMD_CONTINUE, 16'hFFFF, 8'hFE, 8'h00, 17'd1);
        add_check(msf_pkg::CMD_CONTINUE, 16'h0000, 8'hFF);
        // relative step wrapping past 255
        add_write(msf_pkg::REG_MODE_SEL, 8'(msf_pkg::MODE_RELATIVE));
        add_write(msf_pkg::REG_SEARCH_VALUE, 8'h01);
        add_check(msf_pkg::CMD_START, 16'h1234, 8'hFF);
        add_check(msf_pkg::CMD_CONTINUE, 16'h1234, 8'h00);
        add_check(msf_pkg::CMD_CONTINUE, 16'h1234, 8'h05);
        // single bit, flip required then flip forbidden
        add_write(msf_pkg::REG_MODE_SEL, 8'(msf_pkg::MODE_BIT_FLIP));
        add_write(msf_pkg::REG_SEARCH_VALUE, 8'h01);
        add_check(msf_pkg::CMD_START, 16'h00A5, 8'h0F);
        add_check(msf_pkg::CMD_CONTINUE, 16'h00A5, 8'hF0);
        add_check(msf_pkg::CMD_CONTINUE, 16'h00A5, 8'hF1);
        add_write(msf_pkg::REG_SEARCH_VALUE, 8'h00);
        add_check(msf_pkg::CMD_CONTINUE, 16'h00A5, 8'hF1);
        add_check(msf_pkg::CMD_CONTINUE, 16'h00A5, 8'hF0);
        // compare codes, an unknown one never passes
        add_write(msf_pkg::REG_MODE_SEL, 8'(msf_pkg::MODE_COMPARE));
        add_write(msf_pkg::REG_SEARCH_VALUE, msf_pkg::CMP_LT);
        add_check(msf_pkg::CMD_START, 16'h5A5A, 8'h80);
        add_check(msf_pkg::CMD_CONTINUE, 16'h5A5A, 8'h7F);
        add_write(msf_pkg::REG_SEARCH_VALUE, msf_pkg::CMP_GE);
        add_check(msf_pkg::CMD_CONTINUE, 16'h5A5A, 8'h7F);
        add_write(msf_pkg::REG_SEARCH_VALUE, CMP_UNKNOWN);
        add_check(msf_pkg::CMD_CONTINUE, 16'h5A5A, 8'h7F);
        // restart of an entry that still matches
        add_write(msf_pkg::REG_MODE_SEL, 8'(msf_pkg::MODE_ABSOLUTE));
        add_write(msf_pkg::REG_SEARCH_VALUE, 8'h01);
        add_check(msf_pkg::CMD_START, 16'h0000, 8'h01);
        add_check(msf_pkg::CMD_START, 16'h0000, 8'h02);
        add_check(msf_pkg::CMD_QUERY, 16'h5A5A, 8'h00);
    endtask

    // repeated start and continue sweeps over small index windows
    task automatic sweep_random_phases();
        logic [15:0]    base;
        logic [15:0]    idx;
        logic [7:0]     val;
        msf_pkg::mode_t mode;
        int             span;
        int             passes;
        int             roll;
        while (swept < SWEEP_TARGET)
        begin
            steady <= (phases >= 6 && phases < 10);
            mode = msf_pkg::mode_t'($urandom_range(3));
            set_search(mode, draw_search_value(mode));
            case (phases % 9)
                4:       base = 16'hFFF4;
                7:       base = 16'h0000;
                default: base = 16'($urandom);
            endcase
            span   = (phases % 5 == 0) ? $urandom_range(24, 16) : $urandom_range(12, 3);
            passes = $urandom_range(5, 2);
            for (int p = 0; p <= passes; p++)
            begin
                // retune between passes, now and then the mode too
                if (p > 0 && $urandom_range(99) < 20)
                begin
                    if ($urandom_range(3) == 0)
                        mode = msf_pkg::mode_t'($urandom_range(3));
                    set_search(mode, draw_search_value(mode));
                end
                for (int k = 0; k < span; k++)
                begin
                    idx  = base + 16'(k);
                    roll = $urandom_range(99);
                    if (roll >= 11)
                    begin
                        if (p == 0)
                            val = (cur_mode == msf_pkg::MODE_ABSOLUTE && $urandom_range(1)) ?
                                  cur_value : 8'($urandom);
                        else if ($urandom_range(99) < 75)
                            val = keep_candidate_value(idx);
                        else
                            val = 8'($urandom);
                        issue_request(p == 0 ? msf_pkg::CMD_START : msf_pkg::CMD_CONTINUE,
                                      idx, val, 1'b0, '0);
                        swept++;
                    end
                    else if (roll >= 8)
                    begin
                        // noise: any command anywhere
                        issue_request(2'($urandom_range(3)), 16'($urandom), 8'($urandom),
                                      1'b0, '0);
                        swept++;
                    end
                    else if (roll >= 5)
                        issue_request($urandom_range(1) ? msf_pkg::CMD_QUERY : CMD_UNKNOWN,
                                      idx, 8'($urandom), 1'b0, '0);
                    // otherwise the index is skipped, a broken sweep
                end
            end
            phases++;
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = msf_pkg::REG_MODE_SEL;
        cfg_data  = 8'h00;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        steady    = 1'b0;
        for (int i = 0; i < 65536; i++)
        begin
            cand_mask[i] = 8'h00;
            last_byte[i] = 8'h00;
        end
        hit_total = '0;
        cur_mode  = msf_pkg::MODE_ABSOLUTE;
        cur_value = 8'h00;
        build_plan();

        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (plan[i])
        begin
            case (plan[i].kind)
                ROW_WRITE:
                begin
                    wait_drained();
                    write_register(plan[i].sel, plan[i].val);
                end
                ROW_KNOWN:
                    issue_request(plan[i].cmd, plan[i].idx, plan[i].val, 1'b1, plan[i].want);
                default:
                    issue_request(plan[i].cmd, plan[i].idx, plan[i].val, 1'b0, '0);
            endcase
        end

        sweep_random_phases();

        wait_drained();
        repeat (SETTLE)
            @(posedge clk);

        $display("covered %0d requests in %0d random search phases, %0d results checked",
                 sent, phases, checked);
        $display("search settings per mode: absolute %0d, relative %0d, bit %0d, compare %0d",
                 mode_phases[0], mode_phases[1], mode_phases[2], mode_phases[3]);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: files.f
sv/msf_pkg.sv
sv/msf_ram.sv
sv/msf_update.sv
sv/memory_value_search_filter.sv
tb/sv/memory_value_search_filter_test.sv
